[rtl/swlfr_pkg.sv]
// Shared types and constants for the sync word, length prefixed frame receiver.
// Depends on nothing; used by swlfr_core and the top level.
`default_nettype none

package swlfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 32;
  localparam int TIMEOUT_W   = 16;
  localparam int FILL_W      = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] SYNC_BYTES = 8'd4;
  localparam logic [BYTE_W-1:0] MIN_LEN    = 8'd9;
  localparam logic [FILL_W-1:0] FILL_FULL  = 3'd4;

  localparam logic [CODE_W-1:0]    SYNC_CODE_RST = 32'h574B_4C59;
  localparam logic [BYTE_W-1:0]    MAX_LEN_RST   = 8'd255;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

  // item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_LEN,
    ST_TIMEOUT,
    ST_NO_PKT
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0]    sync_code;
    logic [BYTE_W-1:0]    max_frame_len;
    logic [TIMEOUT_W-1:0] tick_limit;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] frame_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              last;
    status_t           status;
  } result_t;

endpackage

`default_nettype wire

[rtl/swlfr_core.sv]
// Frame state machine: start code hunt, length check, body indexing, tick timeout.
// Takes one item per step strobe; depends on swlfr_pkg.
`default_nettype none

module swlfr_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  step,
  input  wire                                  op,
  input  wire  [swlfr_pkg::BYTE_W-1:0]         rx_byte,
  input  swlfr_pkg::cfg_t                      cfg,
  output swlfr_pkg::result_t                   res
);

  localparam int CMP_W = (TIMER_WIDTH > swlfr_pkg::TIMEOUT_W) ? TIMER_WIDTH
                                                              : swlfr_pkg::TIMEOUT_W;
  localparam logic [TIMER_WIDTH-1:0] TICK_MAX = {TIMER_WIDTH{1'b1}};

  swlfr_pkg::phase_t                   phase_r, phase_nxt;
  logic [swlfr_pkg::CODE_W-1:0]        window_r, window_nxt;
  logic [swlfr_pkg::FILL_W-1:0]        fill_r, fill_nxt;
  logic [swlfr_pkg::BYTE_W-1:0]        count_r, count_nxt;
  logic [swlfr_pkg::BYTE_W-1:0]        flen_r, flen_nxt;
  logic [TIMER_WIDTH-1:0]              ticks_r, ticks_nxt;

  logic [TIMER_WIDTH-1:0]              ticks_inc;
  logic                                timed_out;
  logic [swlfr_pkg::CODE_W-1:0]        window_sh;
  logic [swlfr_pkg::FILL_W-1:0]        fill_inc;
  logic [swlfr_pkg::BYTE_W:0]          idx_plus;

  assign ticks_inc = (ticks_r < TICK_MAX) ? ticks_r + 1'b1 : ticks_r;
  assign timed_out = CMP_W'(ticks_inc) >= CMP_W'(cfg.tick_limit);
  assign window_sh = {window_r[swlfr_pkg::CODE_W-swlfr_pkg::BYTE_W-1:0], rx_byte};
  assign fill_inc  = (fill_r < swlfr_pkg::FILL_FULL) ? fill_r + 1'b1 : fill_r;
  assign idx_plus  = {1'b0, count_r} + 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    fill_nxt   = fill_r;
    count_nxt  = count_r;
    flen_nxt   = flen_r;
    ticks_nxt  = ticks_r;
    res        = '{vld: 1'b0, frame_byte: '0, byte_index: '0, last: 1'b0,
                   status: swlfr_pkg::ST_OK};
    if (step) begin
      if (op == swlfr_pkg::OP_TICK) begin
        ticks_nxt = ticks_inc;
        if (timed_out) begin
          res.vld        = 1'b1;
          res.last       = 1'b1;
          res.status     = (phase_r == swlfr_pkg::PH_HUNT) ? swlfr_pkg::ST_NO_PKT
                                                           : swlfr_pkg::ST_TIMEOUT;
          res.byte_index = (phase_r == swlfr_pkg::PH_HUNT) ? '0 : count_r;
        end
      end else begin
        case (phase_r)
          swlfr_pkg::PH_LEN: begin
            flen_nxt       = rx_byte;
            res.vld        = 1'b1;
            res.frame_byte = rx_byte;
            res.byte_index = swlfr_pkg::SYNC_BYTES;
            if (rx_byte < swlfr_pkg::MIN_LEN || rx_byte > cfg.max_frame_len) begin
              res.last   = 1'b1;
              res.status = swlfr_pkg::ST_BAD_LEN;
            end else begin
              phase_nxt = swlfr_pkg::PH_BODY;
              count_nxt = swlfr_pkg::SYNC_BYTES + 1'b1;
            end
          end
          swlfr_pkg::PH_BODY: begin
            res.vld        = 1'b1;
            res.frame_byte = rx_byte;
            res.byte_index = count_r;
            res.last       = idx_plus >= {1'b0, flen_r};
            count_nxt      = idx_plus[swlfr_pkg::BYTE_W-1:0];
          end
          default: begin
            window_nxt = window_sh;
            fill_nxt   = fill_inc;
            if (fill_inc >= swlfr_pkg::FILL_FULL && window_sh == cfg.sync_code) begin
              phase_nxt = swlfr_pkg::PH_LEN;
              count_nxt = swlfr_pkg::SYNC_BYTES;
            end
          end
        endcase
      end
      // any closing result restarts the hunt
      if (res.last) begin
        phase_nxt  = swlfr_pkg::PH_HUNT;
        window_nxt = '0;
        fill_nxt   = '0;
        count_nxt  = '0;
        flen_nxt   = '0;
        ticks_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= swlfr_pkg::PH_HUNT;
      window_r <= '0;
      fill_r   <= '0;
      count_r  <= '0;
      flen_r   <= '0;
      ticks_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      count_r  <= count_nxt;
      flen_r   <= flen_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/sync_word_length_frame_receiver.sv]
// Top level of the sync word, length prefixed frame receiver: input register,
// configuration registers, two-entry result buffer. Uses swlfr_pkg and swlfr_core.
//
//   group | dir | handshake              | content
//   in_   | in  | in_tvalid / in_tready  | tdata rx_byte, tuser op
//   out_  | out | out_tvalid / out_tready| tdata frame_byte, byte_index; tlast; tuser status
//   cfg_  | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; an accepted item sits in
// the input register and any result it yields is registered into the buffer.
// Reset (rst_n low, synchronous) restores register defaults and starts a hunt.
// A stalled output fills the skid entry; in_tready drops only while the skid
// entry is held and an item waits in the input register. cfg_ready is always high.
`default_nettype none

module sync_word_length_frame_receiver #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire         in_tuser,   // [0] op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [15:8] byte_index
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // [1:0] status
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  swlfr_pkg::cfg_t    cfg_r;
  logic               in_vld_r;
  logic               in_op_r;
  logic [7:0]         in_byte_r;
  logic               adv;
  swlfr_pkg::result_t res;
  swlfr_pkg::result_t out_r, skid_r;
  logic               out_vld_r, skid_vld_r;
  logic               push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_code     <= swlfr_pkg::SYNC_CODE_RST;
      cfg_r.max_frame_len <= swlfr_pkg::MAX_LEN_RST;
      cfg_r.tick_limit    <= swlfr_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        swlfr_pkg::REG_SYNC_CODE: cfg_r.sync_code     <= cfg_data;
        swlfr_pkg::REG_MAX_LEN:   cfg_r.max_frame_len <= cfg_data[7:0];
        swlfr_pkg::REG_TIMEOUT:   cfg_r.tick_limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // advance the held item whenever the result buffer has a free entry
  assign adv       = in_vld_r && !skid_vld_r;
  assign in_tready = !in_vld_r || !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  swlfr_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .op     (in_op_r),
    .rx_byte(in_byte_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  assign push = adv && res.vld;
  assign pop  = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        out_vld_r  <= skid_vld_r || push;
        skid_vld_r <= 1'b0;
      end else if (!out_vld_r) begin
        out_vld_r  <= push;
      end else if (push) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (!out_vld_r) begin
      out_r <= res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.byte_index, out_r.frame_byte};
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.status;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != swlfr_pkg::ST_OK |-> out_tlast)
    else $error("error status without last");

  a_no_pkt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == swlfr_pkg::ST_NO_PKT |-> out_tdata == 16'd0)
    else $error("no-packet result carries data");

  a_ok_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == swlfr_pkg::ST_OK |-> out_tdata[15:8] >= 8'd4)
    else $error("frame byte emitted inside start code");

endmodule

`default_nettype wire
